// ===== hdl/mh_pkg.sv =====
// shared types, constants and the arctangent table for the heading block
`default_nettype none

package mh_pkg;

  // frame and cordic sizing
  localparam int FrameBytes  = 6;
  localparam int HeldBytes   = FrameBytes - 1;
  localparam int CntW        = $clog2(FrameBytes);
  localparam int HeldIdxW    = $clog2(HeldBytes);
  localparam int CordicSteps = 20;
  localparam int IterW       = $clog2(CordicSteps);
  localparam int GuardBits   = 16;

  // datapath widths
  localparam int AxisW  = 16;
  localparam int MagW   = AxisW + 1;
  localparam int CordW  = MagW + GuardBits + 3;
  localparam int AccW   = 25;
  localparam int AngW   = 24;
  localparam int DegW   = 9;
  localparam int TabIdxW = 5;

  // angles in q8.16 degrees
  localparam logic [AngW-1:0] Deg45Q  = AngW'(45 * 65536);
  localparam logic [AngW-1:0] Deg90Q  = AngW'(90 * 65536);
  localparam logic [AngW-1:0] Deg180Q = AngW'(180 * 65536);
  localparam logic [DegW-1:0] Deg0    = DegW'(0);
  localparam logic [DegW-1:0] Deg90   = DegW'(90);
  localparam logic [DegW-1:0] Deg180  = DegW'(180);
  localparam logic [DegW-1:0] Deg270  = DegW'(270);
  localparam logic [DegW-1:0] Deg360  = DegW'(360);

  // commands from controller to datapath
  typedef struct packed {
    logic                store_en;
    logic [HeldIdxW-1:0] store_idx;
    logic                start;
    logic                step;
    logic [IterW-1:0]    step_idx;
    logic                finish;
  } mh_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic special;
  } mh_status_t;

  // atan(2^-i) in q8.16 degrees, rounded to nearest
  function automatic logic [AngW-1:0] atan_deg(input logic [TabIdxW-1:0] idx);
    logic [AngW-1:0] v;
    unique case (idx)
      5'd0:  v = AngW'(2949120);
      5'd1:  v = AngW'(1740967);
      5'd2:  v = AngW'(919879);
      5'd3:  v = AngW'(466945);
      5'd4:  v = AngW'(234379);
      5'd5:  v = AngW'(117304);
      5'd6:  v = AngW'(58666);
      5'd7:  v = AngW'(29335);
      5'd8:  v = AngW'(14668);
      5'd9:  v = AngW'(7334);
      5'd10: v = AngW'(3667);
      5'd11: v = AngW'(1833);
      5'd12: v = AngW'(917);
      5'd13: v = AngW'(458);
      5'd14: v = AngW'(229);
      5'd15: v = AngW'(115);
      5'd16: v = AngW'(57);
      5'd17: v = AngW'(29);
      5'd18: v = AngW'(14);
      5'd19: v = AngW'(7);
      5'd20: v = AngW'(4);
      5'd21: v = AngW'(2);
      5'd22: v = AngW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/magnetometer_heading_top.sv =====
// top level of the magnetometer heading block
`default_nettype none

// Takes the six data bytes of one magnetometer read, one byte per transfer, in the
// order X, Z, Y with the high byte first; frame_start_i marks the first byte of a
// read. The sixth byte produces one result: the signed x, y and z words and a heading
// of atan2(-y, x) in whole degrees, 0..359. The five leading bytes are taken one per
// cycle. After the sixth byte the input stalls while a CORDIC unit runs one
// micro-rotation per cycle, stopping after the first when an axis is zero or the
// magnitudes are equal; the quadrant fold-out follows and the result is held until
// its transfer; the input reopens in the cycle after that transfer.
module magnetometer_heading_top
  import mh_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              frame_start_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [AxisW-1:0] field_x_o,
  output logic signed [AxisW-1:0] field_y_o,
  output logic signed [AxisW-1:0] field_z_o,
  output logic [DegW-1:0]        heading_deg_o
);

  mh_cmd_t    cmd;
  mh_status_t status;

  // sequencing
  mh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .frame_start_i (frame_start_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // arithmetic and storage
  mh_dp u_dp (
    .clk_i         (clk_i),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .field_x_o     (field_x_o),
    .field_y_o     (field_y_o),
    .field_z_o     (field_z_o),
    .heading_deg_o (heading_deg_o)
  );

endmodule

`default_nettype wire

// ===== hdl/mh_ctrl.sv =====
// controller: byte counting, cordic sequencing and handshakes
`default_nettype none

module mh_ctrl
  import mh_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       frame_start_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire mh_status_t status_i,
  output mh_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_FINISH,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic [IterW-1:0] iter_q;
  logic             in_stall_q;
  logic             out_valid_q;

  logic             in_xfer;
  logic [CntW-1:0]  cnt_eff;
  logic             last_byte;
  logic             last_iter;

  // byte position of the current transfer
  assign in_xfer   = in_valid_i && !in_stall_q;
  assign cnt_eff   = frame_start_i ? '0 : cnt_q;
  assign last_byte = (cnt_eff == CntW'(HeldBytes));
  assign last_iter = (iter_q == IterW'(CordicSteps - 1));

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.store_en  = in_xfer && !last_byte;
    cmd_o.store_idx = HeldIdxW'(cnt_eff);
    cmd_o.start     = in_xfer && last_byte;
    cmd_o.step      = (state_q == ST_ITER);
    cmd_o.step_idx  = iter_q;
    cmd_o.finish    = (state_q == ST_FINISH);
  end

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      iter_q      <= '0;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (last_byte) begin
              cnt_q      <= '0;
              iter_q     <= '0;
              in_stall_q <= 1'b1;
              state_q    <= ST_ITER;
            end else begin
              cnt_q <= cnt_eff + CntW'(1);
            end
          end
        end
        ST_ITER: begin
          iter_q <= iter_q + IterW'(1);
          if (status_i.special || last_iter) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/mh_dp.sv =====
// datapath: held bytes, axis words, cordic vectoring and heading result
`default_nettype none

module mh_dp
  import mh_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire mh_cmd_t           cmd_i,
  output mh_status_t             status_o,
  output logic signed [AxisW-1:0] field_x_o,
  output logic signed [AxisW-1:0] field_y_o,
  output logic signed [AxisW-1:0] field_z_o,
  output logic [DegW-1:0]        heading_deg_o
);

  logic [7:0]              held_q [HeldBytes];
  logic signed [AxisW-1:0] x_q, y_q, z_q;
  logic signed [CordW-1:0] cx_q, cy_q;
  logic signed [AccW-1:0]  acc_q;
  logic [DegW-1:0]         head_q;

  logic signed [AxisW-1:0] x_new, y_new;
  logic [MagW-1:0]         ax_new, ay_new;
  logic [MagW-1:0]         ax_cur, ay_cur;
  logic                    x_zero, y_zero, mag_eq;
  logic signed [CordW-1:0] dx, dy;
  logic signed [AccW-1:0]  ang;
  logic [AngW-1:0]         t_ang;
  logic [AngW-1:0]         rem_ang;
  logic [DegW-1:0]         td, ud, head_d;

  // incoming axis words, y completed by the current byte
  assign x_new  = {held_q[0], held_q[1]};
  assign y_new  = {held_q[4], data_byte_i};
  assign ax_new = x_new[AxisW-1] ? MagW'(-$signed({x_new[AxisW-1], x_new}))
                                 : MagW'(x_new);
  assign ay_new = y_new[AxisW-1] ? MagW'(-$signed({y_new[AxisW-1], y_new}))
                                 : MagW'(y_new);

  // special cases from the latched words
  assign ax_cur = x_q[AxisW-1] ? MagW'(-$signed({x_q[AxisW-1], x_q})) : MagW'(x_q);
  assign ay_cur = y_q[AxisW-1] ? MagW'(-$signed({y_q[AxisW-1], y_q})) : MagW'(y_q);
  assign x_zero = (x_q == '0);
  assign y_zero = (y_q == '0);
  assign mag_eq = (ax_cur == ay_cur);
  assign status_o.special = x_zero || y_zero || mag_eq;

  // one cordic micro-rotation
  assign dx  = cy_q >>> cmd_i.step_idx;
  assign dy  = cx_q >>> cmd_i.step_idx;
  assign ang = AccW'(atan_deg(TabIdxW'(cmd_i.step_idx)));

  // first quadrant angle, clamped to 0..90 degrees
  always_comb begin
    if (mag_eq) begin
      t_ang = Deg45Q;
    end else if (acc_q < 0) begin
      t_ang = '0;
    end else if (acc_q > $signed(AccW'(Deg90Q))) begin
      t_ang = Deg90Q;
    end else begin
      t_ang = AngW'(acc_q);
    end
  end

  assign rem_ang = Deg180Q - t_ang;
  assign td      = DegW'(t_ang[AngW-1:16]);
  assign ud      = DegW'(rem_ang[AngW-1:16]);

  // quadrant fold-out, truncated toward zero and wrapped into 0..359
  always_comb begin
    priority if (y_zero) begin
      head_d = x_q[AxisW-1] ? Deg180 : Deg0;
    end else if (x_zero) begin
      head_d = y_q[AxisW-1] ? Deg90 : Deg270;
    end else if (!x_q[AxisW-1]) begin
      if (y_q[AxisW-1]) begin
        head_d = td;
      end else begin
        head_d = (td == '0) ? Deg0 : Deg360 - td;
      end
    end else begin
      if (y_q[AxisW-1]) begin
        head_d = ud;
      end else begin
        head_d = (ud == '0) ? Deg0 : Deg360 - ud;
      end
    end
  end

  // held bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en) begin
      held_q[cmd_i.store_idx] <= data_byte_i;
    end
  end

  // axis words, cordic registers and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q   <= x_new;
      y_q   <= y_new;
      z_q   <= {held_q[2], held_q[3]};
      cx_q  <= $signed({3'b000, ax_new, {GuardBits{1'b0}}});
      cy_q  <= $signed({3'b000, ay_new, {GuardBits{1'b0}}});
      acc_q <= '0;
    end else if (cmd_i.step) begin
      if (!cy_q[CordW-1]) begin
        cx_q  <= cx_q + dx;
        cy_q  <= cy_q - dy;
        acc_q <= acc_q + ang;
      end else begin
        cx_q  <= cx_q - dx;
        cy_q  <= cy_q + dy;
        acc_q <= acc_q - ang;
      end
    end
    if (cmd_i.finish) begin
      head_q <= head_d;
    end
  end

  assign field_x_o     = x_q;
  assign field_y_o     = y_q;
  assign field_z_o     = z_q;
  assign heading_deg_o = head_q;

endmodule

`default_nettype wire
